// ----- src/bfwm_pkg.sv -----
// ----------------------------------------------------------------------------
// bfwm_pkg: shared types and constants
// Hash constants, datapath command codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bfwm_pkg;

    localparam int FILTER_SIZE_DEF = 65536;
    localparam int NUM_HASHES_DEF  = 4;

    localparam logic [31:0] C_MUR1  = 32'hcc9e2d51;
    localparam logic [31:0] C_MUR2  = 32'h1b873593;
    localparam logic [31:0] C_MIXN  = 32'he6546b64;
    localparam logic [31:0] C_FMIX1 = 32'h85ebca6b;
    localparam logic [31:0] C_FMIX2 = 32'hc2b2ae35;

    localparam logic [15:0] LEN_MAX = 16'hffff;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLR_INIT,
        CMD_CLR_STEP,
        CMD_LOAD,
        CMD_BLK_MUL1,
        CMD_KEY_MUL2,
        CMD_BLK_MIX,
        CMD_TAIL_MUL1,
        CMD_FIN_XOR,
        CMD_FIN_MUL1,
        CMD_FIN_MUL2,
        CMD_FIN_XOR2,
        CMD_PROBE_LOAD,
        CMD_RED_MUL1,
        CMD_RED_MUL2,
        CMD_RED_FIX,
        CMD_MEM,
        CMD_CHECK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic probe_zero;
        logic probe_one;
        logic done;
    } t_dp_cmd;

    typedef struct packed {
        logic blk;
        logic last;
        logic tail;
        logic clr_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- src/bfwm_ram.sv -----
// ----------------------------------------------------------------------------
// bfwm_ram: generic single-port RAM
// One address, write enable, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfwm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- src/bfwm_dp.sv -----
// ----------------------------------------------------------------------------
// bfwm_dp: hash and probe datapath
// Murmur/Jenkins accumulators, one shared multiplier, reciprocal modulo unit
// and the filter memory port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfwm_dp #(
    parameter int FILTER_SIZE = bfwm_pkg::FILTER_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bfwm_pkg::t_dp_cmd              i_cmd,
    input  wire logic                           i_op,
    input  wire logic [7:0]                     i_byte,
    input  wire logic                           i_last,
    input  wire logic                           i_empty,
    output bfwm_pkg::t_dp_stat                  o_stat,
    output logic                                o_mem_we,
    output logic [$clog2(FILTER_SIZE)-1:0]      o_mem_addr,
    output logic                                o_mem_wdata,
    input  wire logic                           i_mem_rdata,
    output logic                                o_found,
    output logic                                o_was_add,
    output logic                                o_length_error
);

    localparam int IDX_W = $clog2(FILTER_SIZE);
    localparam logic [31:0]      FS_W    = 32'(FILTER_SIZE);
    // floor(2^32 / FILTER_SIZE): quotient estimate is exact or one low
    localparam logic [31:0]      RECIP   = 32'((64'd1 << 32) / 64'(FILTER_SIZE));
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(FILTER_SIZE - 1);

    // word accumulators
    logic [31:0] r_macc, r_jacc;
    logic [23:0] r_block;
    logic [1:0]  r_phase;
    logic [15:0] r_len;
    logic        r_ovf;

    // payload
    logic [31:0] r_k, r_h, r_h1, r_pacc, r_num, r_q;
    logic [7:0]  r_byte;
    logic        r_op, r_last, r_blk, r_allset;
    logic [IDX_W-1:0] r_rem;
    logic        r_found, r_was_add, r_lerr;

    logic        absorb;
    logic [31:0] sx, j1, j2, j3;
    logic [31:0] mul_a, mul_b, prod;
    logic [63:0] prod64;
    logic [31:0] mix_x, mix_r, fin_x, fm2_t, h0, h1a, h1b, h1c;
    logic [31:0] red_d;

    always_comb begin
        absorb = !(i_last && i_empty);
        sx = {{24{i_byte[7]}}, i_byte};
        j1 = r_jacc + sx;
        j2 = j1 + {j1[21:0], 10'b0};
        j3 = j2 ^ {6'b0, j2[31:6]};

        mul_a = r_k;
        mul_b = bfwm_pkg::C_MUR1;
        case (i_cmd.op)
            bfwm_pkg::CMD_BLK_MUL1: begin
                mul_a = {r_byte, r_block};
                mul_b = bfwm_pkg::C_MUR1;
            end
            bfwm_pkg::CMD_TAIL_MUL1: begin
                mul_a = {8'b0, r_block};
                mul_b = bfwm_pkg::C_MUR1;
            end
            bfwm_pkg::CMD_KEY_MUL2: begin
                mul_a = {r_k[16:0], r_k[31:17]};
                mul_b = bfwm_pkg::C_MUR2;
            end
            bfwm_pkg::CMD_FIN_MUL1: begin
                mul_a = r_h;
                mul_b = bfwm_pkg::C_FMIX1;
            end
            bfwm_pkg::CMD_FIN_MUL2: begin
                mul_a = fm2_t;
                mul_b = bfwm_pkg::C_FMIX2;
            end
            bfwm_pkg::CMD_RED_MUL1: begin
                mul_a = r_num;
                mul_b = RECIP;
            end
            bfwm_pkg::CMD_RED_MUL2: begin
                mul_a = r_q;
                mul_b = FS_W;
            end
            default: begin
                mul_a = r_k;
                mul_b = bfwm_pkg::C_MUR1;
            end
        endcase
        prod64 = 64'(mul_a) * 64'(mul_b);
        prod   = prod64[31:0];

        mix_x = r_macc ^ r_k;
        mix_r = {mix_x[18:0], mix_x[31:19]};
        fin_x = r_macc ^ ((r_phase != 2'd0) ? r_k : 32'd0) ^ {16'b0, r_len};
        fm2_t = r_h ^ {13'b0, r_h[31:13]};
        h0    = r_h ^ {16'b0, r_h[31:16]};
        h1a   = r_jacc + {r_jacc[28:0], 3'b0};
        h1b   = h1a ^ {11'b0, h1a[31:11]};
        h1c   = h1b + {h1b[16:0], 15'b0};
        red_d = r_num - FS_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_macc  <= '0;
            r_jacc  <= '0;
            r_block <= '0;
            r_phase <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.done) begin
            r_macc  <= '0;
            r_jacc  <= '0;
            r_block <= '0;
            r_phase <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (i_cmd.op)
                bfwm_pkg::CMD_LOAD: begin
                    if (absorb) begin
                        r_jacc <= j3;
                        if (r_len == bfwm_pkg::LEN_MAX) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_len <= r_len + 16'd1;
                        end
                        case (r_phase)
                            2'd0: begin
                                r_block[7:0] <= i_byte;
                                r_phase <= 2'd1;
                            end
                            2'd1: begin
                                r_block[15:8] <= i_byte;
                                r_phase <= 2'd2;
                            end
                            2'd2: begin
                                r_block[23:16] <= i_byte;
                                r_phase <= 2'd3;
                            end
                            default: begin
                                r_phase <= r_phase;
                            end
                        endcase
                    end
                end
                bfwm_pkg::CMD_BLK_MIX: begin
                    r_macc  <= {mix_r[29:0], 2'b0} + mix_r + bfwm_pkg::C_MIXN;
                    r_block <= '0;
                    r_phase <= '0;
                end
                default: begin
                    r_macc <= r_macc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bfwm_pkg::CMD_CLR_INIT: begin
                r_rem <= '0;
            end
            bfwm_pkg::CMD_CLR_STEP: begin
                r_rem <= r_rem + IDX_W'(1);
            end
            bfwm_pkg::CMD_LOAD: begin
                r_op   <= i_op;
                r_last <= i_last;
                r_byte <= i_byte;
                r_blk  <= absorb && (r_phase == 2'd3);
            end
            bfwm_pkg::CMD_BLK_MUL1, bfwm_pkg::CMD_TAIL_MUL1,
            bfwm_pkg::CMD_KEY_MUL2: begin
                r_k <= prod;
            end
            bfwm_pkg::CMD_FIN_XOR: begin
                r_h <= fin_x ^ {16'b0, fin_x[31:16]};
            end
            bfwm_pkg::CMD_FIN_MUL1: begin
                r_h  <= prod;
                r_h1 <= h1c;
            end
            bfwm_pkg::CMD_FIN_MUL2: begin
                r_h <= prod;
            end
            bfwm_pkg::CMD_FIN_XOR2: begin
                r_h      <= h0;
                r_pacc   <= h0 + {r_h1[30:0], 1'b0};
                r_allset <= 1'b1;
            end
            bfwm_pkg::CMD_PROBE_LOAD: begin
                r_rem <= '0;
                if (i_cmd.probe_zero) begin
                    r_num <= r_h;
                end else if (i_cmd.probe_one) begin
                    r_num <= r_h1;
                end else begin
                    r_num  <= r_pacc;
                    r_pacc <= r_pacc + r_h1;
                end
            end
            bfwm_pkg::CMD_RED_MUL1: begin
                r_q <= prod64[63:32];
            end
            bfwm_pkg::CMD_RED_MUL2: begin
                r_num <= r_num - prod;
            end
            bfwm_pkg::CMD_RED_FIX: begin
                r_rem <= (r_num >= FS_W) ? red_d[IDX_W-1:0] : r_num[IDX_W-1:0];
            end
            bfwm_pkg::CMD_CHECK: begin
                if (r_op) begin
                    r_allset <= r_allset & i_mem_rdata;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (i_cmd.done) begin
            r_found   <= r_op ? r_allset : 1'b1;
            r_was_add <= !r_op;
            r_lerr    <= r_ovf;
        end
    end

    always_comb begin
        o_stat.blk      = r_blk;
        o_stat.last     = r_last;
        o_stat.tail     = (r_phase != 2'd0);
        o_stat.clr_done = (r_rem == IDX_TOP);
        o_mem_addr      = r_rem;
        o_mem_we        = (i_cmd.op == bfwm_pkg::CMD_CLR_STEP)
                          || ((i_cmd.op == bfwm_pkg::CMD_MEM) && !r_op);
        o_mem_wdata     = (i_cmd.op != bfwm_pkg::CMD_CLR_STEP);
        o_found         = r_found;
        o_was_add       = r_was_add;
        o_length_error  = r_lerr;
    end

endmodule

`default_nettype wire

// ----- src/bfwm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfwm_ctrl: sequencer
// Clearing pass, byte intake, block and finalize steps, probe loop, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfwm_ctrl #(
    parameter int NUM_HASHES = bfwm_pkg::NUM_HASHES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output bfwm_pkg::t_dp_cmd       o_cmd,
    input  wire bfwm_pkg::t_dp_stat i_stat
);

    localparam int PRB_W = $clog2(NUM_HASHES);
    localparam logic [PRB_W-1:0] PRB_LAST = PRB_W'(NUM_HASHES - 1);

    typedef enum logic [4:0] {
        S_CLR0, S_CLR, S_IDLE, S_ROUTE, S_BLK1, S_BLK2, S_BLK3,
        S_TAIL1, S_TAIL2, S_FINX, S_FM1, S_FM2, S_FX2,
        S_PLOAD, S_RED1, S_RED2, S_RFIX, S_MEM, S_CHECK, S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [PRB_W-1:0] r_probe, n_probe;
    logic             r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_probe  = r_probe;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd.op = bfwm_pkg::CMD_NONE;
        o_cmd.probe_zero = (r_probe == PRB_W'(0));
        o_cmd.probe_one  = (r_probe == PRB_W'(1));
        o_cmd.done = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR0: begin
                o_cmd.op = bfwm_pkg::CMD_CLR_INIT;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.op = bfwm_pkg::CMD_CLR_STEP;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = bfwm_pkg::CMD_LOAD;
                    n_state = S_ROUTE;
                end
            end
            S_ROUTE: begin
                if (i_stat.blk) begin
                    n_state = S_BLK1;
                end else if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_stat.tail) begin
                    n_state = S_TAIL1;
                end else begin
                    n_state = S_FINX;
                end
            end
            S_BLK1: begin
                o_cmd.op = bfwm_pkg::CMD_BLK_MUL1;
                n_state = S_BLK2;
            end
            S_BLK2: begin
                o_cmd.op = bfwm_pkg::CMD_KEY_MUL2;
                n_state = S_BLK3;
            end
            S_BLK3: begin
                o_cmd.op = bfwm_pkg::CMD_BLK_MIX;
                n_state = i_stat.last ? S_FINX : S_IDLE;
            end
            S_TAIL1: begin
                o_cmd.op = bfwm_pkg::CMD_TAIL_MUL1;
                n_state = S_TAIL2;
            end
            S_TAIL2: begin
                o_cmd.op = bfwm_pkg::CMD_KEY_MUL2;
                n_state = S_FINX;
            end
            S_FINX: begin
                o_cmd.op = bfwm_pkg::CMD_FIN_XOR;
                n_state = S_FM1;
            end
            S_FM1: begin
                o_cmd.op = bfwm_pkg::CMD_FIN_MUL1;
                n_state = S_FM2;
            end
            S_FM2: begin
                o_cmd.op = bfwm_pkg::CMD_FIN_MUL2;
                n_state = S_FX2;
            end
            S_FX2: begin
                o_cmd.op = bfwm_pkg::CMD_FIN_XOR2;
                n_probe = '0;
                n_state = S_PLOAD;
            end
            S_PLOAD: begin
                o_cmd.op = bfwm_pkg::CMD_PROBE_LOAD;
                n_state = S_RED1;
            end
            S_RED1: begin
                o_cmd.op = bfwm_pkg::CMD_RED_MUL1;
                n_state = S_RED2;
            end
            S_RED2: begin
                o_cmd.op = bfwm_pkg::CMD_RED_MUL2;
                n_state = S_RFIX;
            end
            S_RFIX: begin
                o_cmd.op = bfwm_pkg::CMD_RED_FIX;
                n_state = S_MEM;
            end
            S_MEM: begin
                o_cmd.op = bfwm_pkg::CMD_MEM;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.op = bfwm_pkg::CMD_CHECK;
                if (r_probe == PRB_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_probe = r_probe + PRB_W'(1);
                    n_state = S_PLOAD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.done = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR0;
            r_probe  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_probe  <= n_probe;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire

// ----- src/bloom_filter_word_membership.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_word_membership: Bloom filter word add/query
// Byte-serial MurmurHash3 and Jenkins hashing with double-hash probing.
// ----------------------------------------------------------------------------
// After reset the filter memory is swept to zero before the first item is
// taken. A byte that completes a 4-byte block then goes through the shared
// multiplier. The final item of a word goes through hashing and finalization,
// then NUM_HASHES probes (each a modulo by reciprocal multiplication and one
// memory access), then the result hand-off. The result sits in an output
// register; the next word's bytes are taken while it waits, and that word's
// result hand-off stalls until the waiting result is taken.
`default_nettype none

module bloom_filter_word_membership #(
    parameter int FILTER_SIZE = bfwm_pkg::FILTER_SIZE_DEF,
    parameter int NUM_HASHES  = bfwm_pkg::NUM_HASHES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] byte_value
    input  wire logic [1:0] i_s_axis_tuser,   // [0] op, [1] empty_word
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [0] found, [1] length_error
    output logic            o_m_axis_tuser    // [0] was_add
);

    localparam int IDX_W = $clog2(FILTER_SIZE);

    bfwm_pkg::t_dp_cmd  cmd;
    bfwm_pkg::t_dp_stat stat;
    logic               mem_we, mem_wdata, mem_rdata;
    logic [IDX_W-1:0]   mem_addr;
    logic               found, was_add, lerr;

    bfwm_ctrl #(
        .NUM_HASHES(NUM_HASHES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bfwm_dp #(
        .FILTER_SIZE(FILTER_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_s_axis_tuser[0]),
        .i_byte         (i_s_axis_tdata),
        .i_last         (i_s_axis_tlast),
        .i_empty        (i_s_axis_tuser[1]),
        .o_stat         (stat),
        .o_mem_we       (mem_we),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata),
        .i_mem_rdata    (mem_rdata),
        .o_found        (found),
        .o_was_add      (was_add),
        .o_length_error (lerr)
    );

    bfwm_ram #(
        .WIDTH(1),
        .DEPTH(FILTER_SIZE)
    ) u_filter (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_m_axis_tdata = {6'b0, lerr, found};
    assign o_m_axis_tuser = was_add;

endmodule

`default_nettype wire
